[design/drsk_pkg.sv]
// Package for the tableau insertion block: sizes, opcodes and shared types.
// It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package drsk_pkg;
    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int VALUE_BITS = 16;
    localparam int ROW_BITS   = $clog2(MAX_ROWS);
    localparam int COL_BITS   = $clog2(MAX_COLS);
    localparam int LEN_BITS   = $clog2(MAX_COLS + 1);
    localparam int CNT_BITS   = $clog2(MAX_ROWS + 1);
    localparam int ADDR_BITS  = ROW_BITS + COL_BITS;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic REG_ROW_LIMIT = 1'b0;
    localparam logic REG_COL_LIMIT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // latch the input item
        logic len_rd;    // read length of current row (and the row above)
        logic last_rd;   // read last cell of the current row
        logic place;     // write the value and label at the row end
        logic scan_rd;   // read cell at scan column
        logic swap;      // write value at scan column, take displaced entry
        logic scan_next; // advance scan column
        logic row_next;  // advance to next row
        logic new_row;   // open a new row with the value
        logic clear;     // empty the tableau
        logic cell_rd;   // read the requested cell
        logic finish;    // build the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       more_rows;  // current row index below rows in use
        logic       can_place;  // append condition holds
        logic       scan_more;  // scan column below row length
        logic       hit;        // value <= scanned entry
        logic       clr_done;
    } t_stat;
endpackage
`default_nettype wire

[design/drsk_ctrl.sv]
// Controller state machine for the tableau insertion block.
// Depends on drsk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module drsk_ctrl import drsk_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire logic  i_out_busy,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);
    typedef enum logic [10:0] {
        S_INIT  = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_DEC   = 11'b00000000100,
        S_LEN   = 11'b00000001000,
        S_LAST  = 11'b00000010000,
        S_CHK   = 11'b00000100000,
        S_SCAN  = 11'b00001000000,
        S_CMP   = 11'b00010000000,
        S_CLR   = 11'b00100000000,
        S_READ  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            // After reset the row length table is swept to zero.
            S_INIT: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_stat.op)
                    OP_INSERT: n_state = S_LEN;
                    OP_READ: begin
                        o_cmd.cell_rd = 1'b1;
                        n_state       = S_READ;
                    end
                    OP_CLEAR: n_state = S_CLR;
                    default:  n_state = S_DONE;
                endcase
            end
            S_LEN: begin
                if (i_stat.more_rows) begin
                    o_cmd.len_rd = 1'b1;
                    n_state      = S_LAST;
                end else begin
                    o_cmd.new_row = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_LAST: begin
                o_cmd.last_rd = 1'b1;
                n_state       = S_CHK;
            end
            S_CHK: begin
                if (i_stat.can_place) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_more) begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = S_CMP;
                end else begin
                    o_cmd.row_next = 1'b1;
                    n_state        = S_LEN;
                end
            end
            S_CMP: begin
                if (i_stat.hit) begin
                    o_cmd.swap     = 1'b1;
                    o_cmd.row_next = 1'b1;
                    n_state        = S_LEN;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_CLR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_DONE;
                end
            end
            S_READ: n_state = S_DONE;
            S_DONE: begin
                if (!i_out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[design/drsk_dp.sv]
// Datapath for the tableau insertion block: cell memories, row lengths,
// limit registers and the result register. Depends on drsk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module drsk_dp import drsk_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_index,
    input  wire logic [6:0]            i_cfg_data,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [15:0]           i_insert_value,
    input  wire logic [15:0]           i_record_value,
    input  wire logic [5:0]            i_read_row,
    input  wire logic [5:0]            i_read_col,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [5:0]                 o_placed_row,
    output logic [5:0]                 o_placed_col,
    output logic [15:0]                o_cell_value,
    output logic [15:0]                o_cell_record,
    output logic [6:0]                 o_row_length,
    output logic [6:0]                 o_row_count,
    output logic                       o_overflow
);
    logic [VALUE_BITS-1:0] r_ins_mem [MAX_ROWS*MAX_COLS];
    logic [15:0]           r_rec_mem [MAX_ROWS*MAX_COLS];
    logic [LEN_BITS-1:0]   r_len [MAX_ROWS];

    logic [6:0]            r_row_limit, r_col_limit;
    logic [CNT_BITS-1:0]   r_rows_used;
    logic [1:0]            r_op;
    logic [VALUE_BITS-1:0] r_val;
    logic [15:0]           r_label;
    logic [5:0]            r_rr, r_rc;
    logic [ROW_BITS-1:0]   r_row;
    logic [LEN_BITS-1:0]   r_cur_len, r_above_len;
    logic [COL_BITS-1:0]   r_col;
    logic [VALUE_BITS-1:0] r_rdata;
    logic [15:0]           r_rec_rdata;
    logic [ROW_BITS:0]     r_clr_idx;
    logic                  r_first;
    logic                  r_ovf;
    logic [5:0]            r_prow, r_pcol;
    logic [6:0]            r_plen;
    logic [6:0]            r_read_len;
    logic                  r_read_ok;
    logic                  r_row_wrap, r_col_wrap;

    logic [CNT_BITS-1:0]   rlim;
    logic [LEN_BITS-1:0]   clim;
    logic [ADDR_BITS-1:0]  row_base, last_addr, scan_addr, place_addr, rd_addr;
    logic                  gt_last, above_ok;
    logic                  new_ok;

    always_comb begin
        if (r_row_limit == 7'd0) begin
            rlim = CNT_BITS'(1);
        end else if (32'(r_row_limit) > MAX_ROWS) begin
            rlim = CNT_BITS'(MAX_ROWS);
        end else begin
            rlim = CNT_BITS'(r_row_limit);
        end
        if (r_col_limit == 7'd0) begin
            clim = LEN_BITS'(1);
        end else if (32'(r_col_limit) > MAX_COLS) begin
            clim = LEN_BITS'(MAX_COLS);
        end else begin
            clim = LEN_BITS'(r_col_limit);
        end
    end

    assign row_base   = {r_row, {COL_BITS{1'b0}}};
    assign last_addr  = row_base | ADDR_BITS'(r_cur_len - LEN_BITS'(1));
    assign scan_addr  = row_base | ADDR_BITS'(r_col);
    assign place_addr = row_base | ADDR_BITS'(r_cur_len[COL_BITS-1:0]);
    assign rd_addr    = {r_rr[ROW_BITS-1:0], r_rc[COL_BITS-1:0]};
    assign gt_last    = (r_cur_len == '0) || (r_rdata < r_val);
    assign above_ok   = r_first || (r_cur_len < r_above_len);
    // A new row may only be opened below the row limit.
    assign new_ok     = (r_rows_used < rlim);

    assign o_stat.op        = r_op;
    assign o_stat.more_rows = (CNT_BITS'(r_row) < r_rows_used) && !r_row_wrap;
    assign o_stat.can_place = gt_last && (r_cur_len < clim) && above_ok;
    assign o_stat.scan_more = (LEN_BITS'(r_col) < r_cur_len) && !r_col_wrap;
    assign o_stat.hit       = (r_val <= r_rdata);
    assign o_stat.clr_done  = (r_clr_idx == (ROW_BITS+1)'(MAX_ROWS - 1));

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.place) begin
            r_ins_mem[place_addr] <= r_val;
            r_rec_mem[place_addr] <= r_label;
        end else if (i_cmd.new_row && new_ok) begin
            r_ins_mem[{r_rows_used[ROW_BITS-1:0], {COL_BITS{1'b0}}}] <= r_val;
            r_rec_mem[{r_rows_used[ROW_BITS-1:0], {COL_BITS{1'b0}}}] <= r_label;
        end else if (i_cmd.swap) begin
            r_ins_mem[scan_addr] <= r_val;
        end
        if (i_cmd.last_rd) begin
            r_rdata <= r_ins_mem[last_addr];
        end else if (i_cmd.scan_rd) begin
            r_rdata <= r_ins_mem[scan_addr];
        end else if (i_cmd.cell_rd) begin
            r_rdata <= r_ins_mem[rd_addr];
        end
        if (i_cmd.cell_rd) begin
            r_rec_rdata <= r_rec_mem[rd_addr];
        end
    end

    // Row lengths. The table is zeroed one row a cycle by the clearing sweep,
    // which also runs right after reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_len[r_clr_idx[ROW_BITS-1:0]] <= '0;
        end else if (i_cmd.place) begin
            r_len[r_row] <= r_cur_len + LEN_BITS'(1);
        end else if (i_cmd.new_row && new_ok) begin
            r_len[r_rows_used[ROW_BITS-1:0]] <= LEN_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_limit <= 7'd64;
            r_col_limit <= 7'd64;
            r_rows_used <= '0;
            r_clr_idx   <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_ROW_LIMIT) begin
                    r_row_limit <= i_cfg_data;
                end else begin
                    r_col_limit <= i_cfg_data;
                end
            end
            if (i_cmd.clear) begin
                r_clr_idx <= o_stat.clr_done ? '0 : r_clr_idx + 1'b1;
                if (o_stat.clr_done) begin
                    r_rows_used <= '0;
                end
            end
            if (i_cmd.new_row && new_ok) begin
                r_rows_used <= r_rows_used + 1'b1;
            end
            if (i_cmd.finish) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Item registers and walk state.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op       <= i_opcode;
            r_val      <= i_insert_value[VALUE_BITS-1:0];
            r_label    <= i_record_value;
            r_rr       <= i_read_row;
            r_rc       <= i_read_col;
            r_row      <= '0;
            r_row_wrap <= 1'b0;
            r_first    <= 1'b1;
            r_ovf      <= 1'b0;
            r_prow     <= '0;
            r_pcol     <= '0;
            r_plen     <= '0;
            r_cur_len  <= '0;
        end
        if (i_cmd.len_rd) begin
            r_cur_len   <= r_len[r_row];
            r_above_len <= r_first ? '0 : r_len[r_row - 1'b1];
            r_col       <= '0;
            r_col_wrap  <= 1'b0;
        end
        if (i_cmd.scan_next) begin
            {r_col_wrap, r_col} <= {1'b0, r_col} + 1'b1;
        end
        if (i_cmd.swap) begin
            r_val <= r_rdata;
        end
        if (i_cmd.row_next) begin
            {r_row_wrap, r_row} <= {1'b0, r_row} + 1'b1;
            r_first <= 1'b0;
        end
        if (i_cmd.place) begin
            r_prow   <= 6'(r_row);
            r_pcol   <= 6'(r_cur_len);
            r_plen   <= 7'(r_cur_len) + 7'd1;
        end
        if (i_cmd.new_row) begin
            if (new_ok) begin
                r_prow   <= 6'(r_rows_used);
                r_pcol   <= '0;
                r_plen   <= 7'd1;
            end else begin
                r_ovf <= 1'b1;
            end
        end
        if (i_cmd.cell_rd) begin
            r_read_len <= (32'(r_rr) < MAX_ROWS) ? 7'(r_len[r_rr[ROW_BITS-1:0]]) : 7'd0;
            r_read_ok  <= (32'(r_rr) < MAX_ROWS) && (32'(r_rc) < MAX_COLS)
                && (7'(r_rc) < 7'(r_len[r_rr[ROW_BITS-1:0]]));
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_placed_row  <= '0;
            o_placed_col  <= '0;
            o_cell_value  <= '0;
            o_cell_record <= '0;
            o_row_length  <= '0;
            o_overflow    <= 1'b0;
            o_row_count   <= 7'(r_rows_used);
            if (r_op == OP_INSERT) begin
                o_placed_row <= r_prow;
                o_placed_col <= r_pcol;
                o_row_length <= r_plen;
                o_overflow   <= r_ovf;
            end else if (r_op == OP_READ) begin
                o_row_length <= r_read_len;
                if (r_read_ok) begin
                    o_cell_value  <= 16'(r_rdata);
                    o_cell_record <= r_rec_rdata;
                end
            end
        end
    end
endmodule
`default_nettype wire

[design/dual_rsk_tableau_insert.sv]
// Top level of the tableau insertion block: joins controller and datapath.
// Depends on drsk_pkg, drsk_ctrl and drsk_dp.
//
// Use: items enter on the input channel (i_in_valid / o_in_ready) with an
// opcode: insert a value with its label, read one cell, or clear the tableau.
// Every item gives exactly one result transfer on the output channel
// (o_out_valid / i_out_ready). Row and column limits are written on the
// configuration channel (index 0 row limit, index 1 column limit); it is
// always ready and must be used only while the block is idle.
// The block takes one item at a time. An insert walks the rows through one
// memory port: per row it reads the row length and the last cell and checks
// whether the value can be appended; if not, it scans the row for the first
// entry not smaller than the value, swaps the value in and goes to the next row
// with the displaced entry, or with the value if no such entry is found. A
// read looks up the cell and its row length. A clear sweeps the row length
// table one row a cycle. The result lands in an output register; while the
// receiver stalls it holds, the next item is accepted and worked through, and
// its result and further input wait until the pending result transfer. Reset
// (synchronous, active low) sets both limits to 64 and starts a sweep that
// empties the row length table, during which the input is not ready; cell
// memories are not cleared, since no cell outside a row length can be read.
`timescale 1ns / 1ps
`default_nettype none
module dual_rsk_tableau_insert import drsk_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [15:0] i_insert_value,
    input  wire logic [15:0] i_record_value,
    input  wire logic [5:0]  i_read_row,
    input  wire logic [5:0]  i_read_col,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [5:0]       o_placed_row,
    output logic [5:0]       o_placed_col,
    output logic [15:0]      o_cell_value,
    output logic [15:0]      o_cell_record,
    output logic [6:0]       o_row_length,
    output logic [6:0]       o_row_count,
    output logic             o_overflow
);
    t_cmd  cmd;
    t_stat stat;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    drsk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_busy (o_out_valid && !i_out_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    drsk_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_insert_value (i_insert_value),
        .i_record_value (i_record_value),
        .i_read_row     (i_read_row),
        .i_read_col     (i_read_col),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_placed_row   (o_placed_row),
        .o_placed_col   (o_placed_col),
        .o_cell_value   (o_cell_value),
        .o_cell_record  (o_cell_record),
        .o_row_length   (o_row_length),
        .o_row_count    (o_row_count),
        .o_overflow     (o_overflow)
    );
endmodule
`default_nettype wire
